// ===== sv/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps
package gtg_pkg;

   typedef enum logic [1:0] {
      CMD_POSE = 2'd0,
      CMD_GOAL = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic signed [15:0]  heading;
   } req_type;

   typedef struct packed {
      logic signed [12:0]  surge;
      logic signed [15:0]  yaw_rate;
      logic [17:0]         distance;
      logic                reached;
   } rsp_type;

   // one control tick handed from the front to the back part
   typedef struct packed {
      logic signed [16:0]  dx;
      logic signed [16:0]  dy;
      logic signed [15:0]  heading;
      logic [15:0]         heading_gain;
      logic [15:0]         speed_gain;
      logic [15:0]         tolerance;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ITER = 2'd1,
      ST_POST = 2'd2,
      ST_OUT  = 2'd3
   } state_type;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;

   localparam logic [1:0] REG_HEADING_GAIN = 2'd0;
   localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
   localparam logic [1:0] REG_TOLERANCE    = 2'd2;

   localparam logic [15:0] HEADING_GAIN_RST = 16'd4096;
   localparam logic [15:0] SPEED_GAIN_RST   = 16'd4096;
   localparam logic [15:0] TOLERANCE_RST    = 16'd102;
   localparam logic signed [15:0] GOAL_X_RST = 16'sd4096;
   localparam logic signed [15:0] GOAL_Y_RST = 16'sd12288;

   localparam logic signed [18:0] ANG_PI     = 19'sd25736;
   localparam logic signed [18:0] ANG_2PI    = 19'sd51472;
   localparam logic signed [23:0] HALF_PI_Z  = 24'sd1647099;
   localparam logic [15:0]        MAG_COMP   = 16'd39796;

   // arctangent of 2^-i in units of 2^-20 rad
   function automatic logic [19:0] atan_lut(input logic [4:0] i);
      logic [19:0] r;
      case (i)
         5'd0:  r = 20'd823550;
         5'd1:  r = 20'd486170;
         5'd2:  r = 20'd256879;
         5'd3:  r = 20'd130396;
         5'd4:  r = 20'd65451;
         5'd5:  r = 20'd32757;
         5'd6:  r = 20'd16383;
         5'd7:  r = 20'd8192;
         5'd8:  r = 20'd4096;
         5'd9:  r = 20'd2048;
         5'd10: r = 20'd1024;
         5'd11: r = 20'd512;
         5'd12: r = 20'd256;
         5'd13: r = 20'd128;
         5'd14: r = 20'd64;
         5'd15: r = 20'd32;
         5'd16: r = 20'd16;
         5'd17: r = 20'd8;
         5'd18: r = 20'd4;
         5'd19: r = 20'd2;
         5'd20: r = 20'd1;
         5'd21: r = 20'd1;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/gtg_front.sv =====
// Front part: configuration registers, pose and goal state, tick classification.
`timescale 1ns / 1ps
module gtg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  gtg_pkg::req_type  req_word,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              job_valid,
   input  logic              job_ready,
   output gtg_pkg::job_type  job_word,
   input  logic              done_valid,
   input  logic              done_reached
);
   import gtg_pkg::*;

   logic [15:0]        hgain_ff, sgain_ff, tol_ff;
   logic signed [15:0] pose_x_ff, pose_y_ff, pose_h_ff, goal_x_ff, goal_y_ff;
   logic               active_ff;
   // a tick is outstanding until the back part reports its end
   logic               busy_ff;
   logic               wr;
   logic [1:0]         reg_idx;
   logic               accept;
   cmd_type            cmd;

   assign reg_idx = csr_paddr[3:2];
   assign wr      = csr_psel && csr_penable && csr_pwrite;
   assign cmd     = cmd_type'(req_word.cmd);
   // the active flag is only known after the tick in flight ends
   assign req_full  = busy_ff || !job_ready;
   assign accept    = req_push && !req_full;
   assign job_valid = accept && cmd == CMD_TICK && active_ff;

   always_comb begin
      job_word.dx = 17'(goal_x_ff) - 17'(pose_x_ff);
      job_word.dy = 17'(goal_y_ff) - 17'(pose_y_ff);
      job_word.heading      = pose_h_ff;
      job_word.heading_gain = hgain_ff;
      job_word.speed_gain   = sgain_ff;
      job_word.tolerance    = tol_ff;
   end

   // register read back
   always_comb begin
      case (reg_idx)
         REG_HEADING_GAIN: csr_prdata = {16'd0, hgain_ff};
         REG_SPEED_GAIN:   csr_prdata = {16'd0, sgain_ff};
         REG_TOLERANCE:    csr_prdata = {16'd0, tol_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hgain_ff  <= HEADING_GAIN_RST;
         sgain_ff  <= SPEED_GAIN_RST;
         tol_ff    <= TOLERANCE_RST;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
         goal_x_ff <= GOAL_X_RST;
         goal_y_ff <= GOAL_Y_RST;
         active_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         if (wr) begin
            case (reg_idx)
               REG_HEADING_GAIN: hgain_ff <= csr_pwdata[15:0];
               REG_SPEED_GAIN:   sgain_ff <= csr_pwdata[15:0];
               REG_TOLERANCE:    tol_ff   <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (accept) begin
            case (cmd)
               CMD_POSE: begin
                  pose_x_ff <= req_word.pos_x;
                  pose_y_ff <= req_word.pos_y;
                  pose_h_ff <= req_word.heading;
               end
               CMD_GOAL: begin
                  goal_x_ff <= req_word.pos_x;
                  goal_y_ff <= req_word.pos_y;
                  active_ff <= 1'b1;
               end
               default: ;
            endcase
         end
         if (job_valid) busy_ff <= 1'b1;
         if (done_valid) begin
            busy_ff <= 1'b0;
            if (done_reached) active_ff <= 1'b0;
         end
      end
   end
endmodule

// ===== sv/gtg_queue.sv =====
// Two-entry word queue between the front and back parts.
`timescale 1ns / 1ps
module gtg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gtg_pkg::job_type  in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output gtg_pkg::job_type  out_word
);
   import gtg_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_word  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule

// ===== sv/gtg_back.sv =====
// Back part: iterative CORDIC vectoring, then scaling, wrapping and clamping.
`timescale 1ns / 1ps
module gtg_back #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  gtg_pkg::job_type  job_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output gtg_pkg::rsp_type  rsp_word,
   output logic              done_valid,
   output logic              done_reached
);
   import gtg_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam logic [4:0] LAST = 5'(STEPS - 1);

   state_type          state_ff, state_in;
   logic signed [23:0] x_ff, y_ff, x_in, y_in;
   logic signed [23:0] z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               zero_ff;
   logic signed [15:0] head_ff;
   logic [15:0]        hg_ff, sg_ff, tol_ff;
   logic [1:0]         post_ff, post_in;
   logic [17:0]        dist_ff;
   logic signed [18:0] err_ff;
   logic               full_ff;
   rsp_type            out_ff;

   // CORDIC step datapath
   logic signed [23:0] xs, ys, at;
   // post-processing
   logic [39:0]        magp;
   logic [20:0]        magr;
   logic signed [23:0] bear;
   logic signed [18:0] e0, ew;
   logic signed [36:0] yp;
   logic signed [22:0] yr;
   logic [33:0]        sp;
   logic [21:0]        sr;
   logic signed [15:0] yaw;
   logic signed [12:0] surge;
   logic               load, emit;

   assign job_ready = state_ff == ST_IDLE;
   assign load = job_valid && job_ready;
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = 24'(atan_lut(i_ff));

   assign magp = 40'(x_ff[23] ? 24'd0 : x_ff) * 40'(MAG_COMP) + (40'd1 << 19);
   assign magr = 21'(magp[39:20]);
   assign bear = (z_ff + 24'sd64) >>> 7;
   assign e0 = 19'(head_ff) - (zero_ff ? 19'sd0 : 19'(bear));
   assign ew = (e0 > ANG_PI) ? e0 - ANG_2PI : ((e0 < -ANG_PI) ? e0 + ANG_2PI : e0);
   assign yp = 37'sd8192 - 37'($signed({1'b0, hg_ff})) * 37'(err_ff);
   assign yr = 23'(yp >>> 14);
   assign yaw = (yr > 23'sd32767) ? 16'sh7fff : ((yr < -23'sd32768) ? 16'sh8000 : 16'(yr));
   assign sp = 34'(sg_ff) * 34'(dist_ff) + 34'd2048;
   assign sr = sp[33:12];
   assign surge = (sr > 22'd2048) ? 13'sd2048 : 13'(sr);
   assign emit = state_ff == ST_OUT && !full_ff;

   assign rsp_empty    = !full_ff;
   assign rsp_word     = out_ff;
   assign done_valid   = emit;
   assign done_reached = dist_ff < 18'(tol_ff);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      post_in = post_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               // pre-rotate into the right half plane, scale by 16
               if (job_word.dx[16]) begin
                  if (!job_word.dy[16]) begin
                     x_in = 24'(job_word.dy) <<< 4;
                     y_in = -(24'(job_word.dx) <<< 4);
                     z_in = HALF_PI_Z;
                  end else begin
                     x_in = -(24'(job_word.dy) <<< 4);
                     y_in = 24'(job_word.dx) <<< 4;
                     z_in = -HALF_PI_Z;
                  end
               end else begin
                  x_in = 24'(job_word.dx) <<< 4;
                  y_in = 24'(job_word.dy) <<< 4;
                  z_in = '0;
               end
               i_in = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (!y_ff[23]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end
            i_in = i_ff + 5'd1;
            post_in = '0;
            if (i_ff == LAST) state_in = ST_POST;
         end
         ST_POST: begin
            post_in = post_ff + 2'd1;
            if (post_ff == 2'd1) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) full_ff <= 1'b1;
         else if (rsp_pop) full_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
      post_ff <= post_in;
      if (load) begin
         zero_ff <= job_word.dx == '0 && job_word.dy == '0;
         head_ff <= job_word.heading;
         hg_ff   <= job_word.heading_gain;
         sg_ff   <= job_word.speed_gain;
         tol_ff  <= job_word.tolerance;
      end
      // first post cycle: magnitude and wrapped error; second: gains
      if (state_ff == ST_POST && post_ff == 2'd0) begin
         dist_ff <= (magr > 21'd262143) ? 18'h3ffff : 18'(magr);
         err_ff  <= ew;
      end
      if (state_ff == ST_POST && post_ff == 2'd1) begin
         out_ff.surge    <= surge;
         out_ff.yaw_rate <= yaw;
         out_ff.distance <= dist_ff;
         out_ff.reached  <= done_reached;
      end
   end
endmodule

// ===== sv/go_to_goal_unicycle_controller.sv =====
// Top level of the go-to-goal unicycle controller.
// Pose (cmd 0), goal (cmd 1) and tick (cmd 2) words enter through req_push/req_full; a
// tick while a goal is active gives one result word on the rsp_ queue. For an active
// tick the result word is formed by the iterative CORDIC, which does one micro-rotation
// a cycle, and then by the post-processing; further words wait until the tick ends, and
// longer while an earlier result word has not been popped. Gains and tolerance sit at
// csr_ byte addresses 0, 4 and 8.
`timescale 1ns / 1ps
module go_to_goal_unicycle_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  gtg_pkg::req_type  req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output gtg_pkg::rsp_type  rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import gtg_pkg::*;

   logic    fj_valid, fj_ready, bj_valid, bj_ready, done_valid, done_reached;
   job_type fj_word, bj_word;

   assign pready = 1'b1;

   gtg_front u_front (
      .clock, .reset, .req_push, .req_full, .req_word,
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_word(fj_word),
      .done_valid, .done_reached
   );

   gtg_queue u_queue (
      .clock, .reset,
      .in_valid(fj_valid), .in_ready(fj_ready), .in_word(fj_word),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_word(bj_word)
   );

   gtg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job_word(bj_word),
      .rsp_empty, .rsp_pop, .rsp_word, .done_valid, .done_reached
   );
endmodule

// ===== bench/tb_go_to_goal_unicycle_controller.sv =====
// Self-checking testbench for the go-to-goal unicycle controller.
`timescale 1ns / 1ps
module tb_go_to_goal_unicycle_controller;
   import gtg_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_word;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   go_to_goal_unicycle_controller dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Controller predictor and store of pending results
   class steer_board;
      logic [15:0] lambda_q, gamma_q, tol_q;
      longint px, py, ph, gx, gy;
      bit live;
      rsp_type pending[$];
      int n_bad, n_rsp, n_ticks, n_hits;

      function void clear_state();
         lambda_q = HEADING_GAIN_RST; gamma_q = SPEED_GAIN_RST; tol_q = TOLERANCE_RST;
         px = 0; py = 0; ph = 0; gx = 4096; gy = 12288; live = 0;
      endfunction

      function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint arctan_step(int i);
         longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                           4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0};
         return t[i];
      endfunction

      function void note_word(req_type w);
         longint dx, dy, x, y, z, nx, ny, brg, err, dlen, yaw, sg;
         rsp_type r;
         case (cmd_type'(w.cmd))
            CMD_POSE: begin px = w.pos_x; py = w.pos_y; ph = w.heading; end
            CMD_GOAL: begin gx = w.pos_x; gy = w.pos_y; live = 1; end
            CMD_TICK: if (live) begin
               dx = gx - px; dy = gy - py; z = 0;
               if (dx < 0) begin
                  if (dy >= 0) begin x = dy; y = -dx; z = 1647099; end
                  else begin x = -dy; y = dx; z = -1647099; end
               end else begin x = dx; y = dy; end
               x *= 16; y *= 16;
               for (int i = 0; i < STEPS && i < 24; i++) begin
                  if (y >= 0) begin
                     nx = x + shr(y, i); ny = y - shr(x, i); z += arctan_step(i);
                  end else begin
                     nx = x - shr(y, i); ny = y + shr(x, i); z -= arctan_step(i);
                  end
                  x = nx; y = ny;
               end
               brg = (dx == 0 && dy == 0) ? 0 : shr(z + 64, 7);
               if (x < 0) x = 0;
               dlen = (x * 39796 + (longint'(1) << 19)) >>> 20;
               if (dlen > 262143) dlen = 262143;
               err = ph - brg;
               if (err > 25736) err -= 51472;
               else if (err < -25736) err += 51472;
               yaw = shr(-(longint'(lambda_q) * err) + 8192, 14);
               if (yaw > 32767) yaw = 32767;
               if (yaw < -32768) yaw = -32768;
               sg = (longint'(gamma_q) * dlen + 2048) >>> 12;
               if (sg > 2048) sg = 2048;
               r.surge = sg[12:0]; r.yaw_rate = yaw[15:0]; r.distance = dlen[17:0];
               r.reached = dlen < tol_q;
               if (r.reached) begin live = 0; n_hits++; end
               n_ticks++;
               pending.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         n_rsp++;
         if (pending.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) $display("mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass

   steer_board sb = new();

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("go_to_goal_unicycle_controller verification failed");
      $finish;
   end

   // Receiver: stall pattern of its own, check on pop
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_word(rsp_word);
   end
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else case (stall_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 3) != 0);
         default: rsp_pop <= ($urandom_range(0, 3) == 0);
      endcase
   end
   always @(posedge clock) if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);

   // APB register write, setup then access
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_HEADING_GAIN: sb.lambda_q = val;
         REG_SPEED_GAIN:   sb.gamma_q = val;
         default:          sb.tol_q = val;
      endcase
   endtask

   // Push one word; returns once accepted
   task automatic send_word(cmd_type c, logic [15:0] x, logic [15:0] y, logic [15:0] h);
      req_type w;
      w.cmd = c; w.pos_x = x; w.pos_y = y; w.heading = h;
      @(negedge clock);
      req_push <= 1'b1; req_word <= w;
      do @(posedge clock); while (req_full);
      sb.note_word(w);
   endtask

   task automatic pause_gap();
      int g;
      g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
      if (g != 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // Wait for all results, then let an in-flight idle tick drain
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (STEPS + 20) @(negedge clock);
   endtask

   function automatic logic [15:0] rnd_heading();
      return 16'($signed($urandom_range(0, 51472)) - 25736);
   endfunction

   // Mostly ticks, with goals, poses and noise words mixed in at random
   task automatic random_burst(int count);
      int left, b;
      left = count;
      while (left > 0) begin
         b = $urandom_range(1, 12);
         for (int k = 0; k < b && left > 0; k++, left--) begin
            case ($urandom_range(0, 9))
               0: send_word(CMD_GOAL, 16'($urandom), 16'($urandom), 16'($urandom));
               1, 2: send_word(CMD_POSE, 16'($urandom), 16'($urandom),
                               ($urandom_range(0, 7) == 0) ? 16'($urandom) : rnd_heading());
               3: send_word(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
               4: send_word(CMD_GOAL, 16'(sb.px + $signed($urandom_range(0, 200)) - 100),
                            16'(sb.py + $signed($urandom_range(0, 200)) - 100),
                            16'($urandom));
               default: send_word(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
            endcase
         end
         pause_gap();
      end
   endtask

   initial begin
      sb.clear_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, reset goal, extremes, goal at pose, wide heading, cmd 3
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(CMD_GOAL, 4096, 12288, 16'h1234);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_POSE, 16'h8000, 16'h8000, 16'sd25736);
      send_word(CMD_GOAL, 16'h7FFF, 16'h7FFF, 0);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_POSE, 16'h7FFF, 16'h8000, -16'sd25736);
      send_word(CMD_GOAL, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_POSE, 100, -200, 16'h7FFF);
      send_word(CMD_GOAL, -300, -200, 0);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_POSE, 100, -200, 16'h8000);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_GOAL, 100, -200, 0);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_GOAL, 150, -200, 0);
      send_word(CMD_TICK, 0, 0, 0);
      send_word(CMD_POSE, 0, 0, 0);
      send_word(CMD_GOAL, 16'hFFFF, 16'hFFFF, 0);
      send_word(CMD_TICK, 0, 0, 0);
      drain();

      // phases of register settings, extremes first
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(REG_HEADING_GAIN, 16'hFFFF); write_reg(REG_SPEED_GAIN, 16'hFFFF);
                     write_reg(REG_TOLERANCE, 16'hFFFF); end
            1: begin write_reg(REG_HEADING_GAIN, 0); write_reg(REG_SPEED_GAIN, 0);
                     write_reg(REG_TOLERANCE, 0); end
            2: begin write_reg(REG_HEADING_GAIN, HEADING_GAIN_RST);
                     write_reg(REG_SPEED_GAIN, SPEED_GAIN_RST);
                     write_reg(REG_TOLERANCE, TOLERANCE_RST); end
            default: begin write_reg(REG_HEADING_GAIN, 16'($urandom));
                     write_reg(REG_SPEED_GAIN, 16'($urandom_range(0, 8192)));
                     write_reg(REG_TOLERANCE, 16'($urandom_range(0, 4000))); end
         endcase
         random_burst(300);
         drain();
      end

      $display("covered %0d result words from %0d active ticks, %0d goals reached",
               sb.n_rsp, sb.n_ticks, sb.n_hits);
      if (sb.n_bad == 0 && sb.pending.size() == 0)
         $display("go_to_goal_unicycle_controller verification clean");
      else
         $display("go_to_goal_unicycle_controller verification failed");
      $finish;
   end
endmodule
